[rtl/core/mbss_pkg.sv]
`timescale 1ns / 1ps

package mbss_pkg;

    localparam int BYTE_BITS             = 8;
    localparam int PATTERN_SLOTS         = 32;
    localparam int SLOT_BITS             = 5;
    localparam int PATTERN_WORD_BITS     = 64;
    localparam int PATTERN_WORDS         = 4;
    localparam int PATTERN_BITS          = PATTERN_WORDS * PATTERN_WORD_BITS;
    localparam int LENGTH_BITS           = 6;
    localparam int VALUE_BITS            = 32;
    localparam int OFFSET_BITS           = 32;
    localparam int STATUS_BITS           = 2;
    localparam int CFG_INDEX_BITS        = 4;
    localparam int CFG_DATA_BITS         = 64;
    localparam int FOLLOW_COUNT_BITS     = 2;

    localparam int MAX_PATTERN_BYTES_DEF = 32;

    // Width of the address space that match addresses wrap in.
    localparam int ADDRESS_BITS          = 32;

    localparam logic [VALUE_BITS-1:0] ADDR_MASK = (ADDRESS_BITS >= VALUE_BITS) ?
        {VALUE_BITS{1'b1}} : VALUE_BITS'((64'd1 << ADDRESS_BITS) - 64'd1);

    localparam logic [STATUS_BITS-1:0] STATUS_NOT_FOUND = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_FOUND     = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_CUT_SHORT = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_0      = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_1      = 4'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_2      = 4'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_3      = 4'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CARE_MASK      = 4'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LENGTH = 4'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FOLLOW_MODE    = 4'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BASE_ADDRESS   = 4'd7;

    localparam logic [FOLLOW_COUNT_BITS-1:0] FOLLOW_LAST_BYTE = 2'd3;

    typedef struct packed {
        logic [SLOT_BITS-1:0]  len_m1;
        logic [VALUE_BITS-1:0] base_adj;
    } setup_t;

endpackage

[rtl/core/mbss_cell.sv]
`timescale 1ns / 1ps

module mbss_cell (
    input  logic                           clk,
    input  logic                           shift_en,
    input  logic [mbss_pkg::BYTE_BITS-1:0] byte_in,
    input  logic [mbss_pkg::BYTE_BITS-1:0] pattern_byte,
    input  logic                           care,
    output logic [mbss_pkg::BYTE_BITS-1:0] byte_out,
    output logic                           hit
);
    import mbss_pkg::*;

    logic [BYTE_BITS-1:0] byte_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            byte_reg <= byte_in;
        end
    end

    // The compare looks at the byte entering this slot, so the whole row
    // judges the window as it stands after the current byte.
    assign hit      = !care || (byte_in == pattern_byte);
    assign byte_out = byte_reg;

endmodule

[rtl/core/mbss_align.sv]
`timescale 1ns / 1ps

module mbss_align #(
    parameter int MAX_BYTES = mbss_pkg::MAX_PATTERN_BYTES_DEF
) (
    input  logic                                          clk,
    input  logic [mbss_pkg::PATTERN_BITS-1:0]             pattern_flat,
    input  logic [mbss_pkg::PATTERN_SLOTS-1:0]            care_mask,
    input  logic [mbss_pkg::LENGTH_BITS-1:0]              pattern_length,
    input  logic [mbss_pkg::VALUE_BITS-1:0]               base_address,
    output logic [MAX_BYTES-1:0][mbss_pkg::BYTE_BITS-1:0] aligned_byte,
    output logic [MAX_BYTES-1:0]                          aligned_care,
    output mbss_pkg::setup_t                              setup
);
    import mbss_pkg::*;

    localparam logic [LENGTH_BITS-1:0] MAX_LEN = LENGTH_BITS'(MAX_BYTES);

    logic [MAX_BYTES-1:0][BYTE_BITS-1:0] aligned_byte_reg;
    logic [MAX_BYTES-1:0][BYTE_BITS-1:0] aligned_byte_next;
    logic [MAX_BYTES-1:0]                aligned_care_reg;
    logic [MAX_BYTES-1:0]                aligned_care_next;
    setup_t                              setup_reg;
    setup_t                              setup_next;
    logic [LENGTH_BITS-1:0]              len_eff;

    always_comb
    begin
        if (pattern_length == '0)
        begin
            len_eff = LENGTH_BITS'(1);
        end
        else if (pattern_length > MAX_LEN)
        begin
            len_eff = MAX_LEN;
        end
        else
        begin
            len_eff = pattern_length;
        end
        setup_next.len_m1   = SLOT_BITS'(len_eff - LENGTH_BITS'(1));
        setup_next.base_adj = base_address - VALUE_BITS'(setup_next.len_m1);
    end

    // Window slot j (newest byte in slot 0) faces pattern byte len-1-j.
    always_comb
    begin
        logic [SLOT_BITS-1:0] slot;
        slot = '0;
        for (int j = 0; j < MAX_BYTES; j++)
        begin
            slot                 = setup_next.len_m1 - SLOT_BITS'(j);
            aligned_byte_next[j] = pattern_flat[{slot, 3'b000} +: BYTE_BITS];
            aligned_care_next[j] = (SLOT_BITS'(j) <= setup_next.len_m1) && care_mask[slot];
        end
    end

    always_ff @(posedge clk)
    begin
        aligned_byte_reg <= aligned_byte_next;
        aligned_care_reg <= aligned_care_next;
        setup_reg        <= setup_next;
    end

    assign aligned_byte = aligned_byte_reg;
    assign aligned_care = aligned_care_reg;
    assign setup        = setup_reg;

endmodule

[rtl/core/masked_byte_signature_scan.sv]
`timescale 1ns / 1ps

// Scans a region one byte per cycle for the first occurrence of a masked byte
// pattern and reports its address, or in follow mode the little-endian word
// after it. A new byte is taken in every cycle; the only stalls come from a
// full result register that the consumer is holding, and from the cycle
// after each configuration write, in which the pattern is re-aligned onto
// the row of window cells. Each byte is compared in the cycle it is taken,
// across all window cells in parallel, and its result (if any) is offered
// on the output in the next cycle. There is no clearing pass; after reset
// input is stalled while the reset pattern is aligned.
module masked_byte_signature_scan #(
    parameter int MAX_PATTERN_BYTES = mbss_pkg::MAX_PATTERN_BYTES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [mbss_pkg::BYTE_BITS-1:0]      data_byte,
    input  logic                                last_byte,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [mbss_pkg::STATUS_BITS-1:0]    status,
    output logic [mbss_pkg::VALUE_BITS-1:0]     value,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mbss_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [mbss_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import mbss_pkg::*;

    logic [PATTERN_WORDS-1:0][PATTERN_WORD_BITS-1:0] pattern_reg;
    logic [PATTERN_SLOTS-1:0]                        care_reg;
    logic [LENGTH_BITS-1:0]                          length_reg;
    logic                                            follow_reg;
    logic [VALUE_BITS-1:0]                           base_reg;
    logic                                            refresh_reg;

    logic [MAX_PATTERN_BYTES-1:0][BYTE_BITS-1:0] aligned_byte;
    logic [MAX_PATTERN_BYTES-1:0]                aligned_care;
    setup_t                                      setup;

    logic [MAX_PATTERN_BYTES-1:0][BYTE_BITS-1:0] chain;
    logic [MAX_PATTERN_BYTES-1:0]                hit;

    logic [OFFSET_BITS-1:0]       offset_reg;
    logic [OFFSET_BITS-1:0]       offset_next;
    logic                         given_reg;
    logic                         given_next;
    logic                         collecting_reg;
    logic                         collecting_next;
    logic [FOLLOW_COUNT_BITS-1:0] fcount_reg;
    logic [FOLLOW_COUNT_BITS-1:0] fcount_next;
    logic [VALUE_BITS-1:0]        fword_reg;
    logic [VALUE_BITS-1:0]        fword_next;

    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [STATUS_BITS-1:0]       status_reg;
    logic [VALUE_BITS-1:0]        value_reg;

    logic                         in_accept;
    logic                         shift_en;
    logic                         window_hit;
    logic                         emit;
    logic [STATUS_BITS-1:0]       emit_status;
    logic [VALUE_BITS-1:0]        emit_value;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            care_reg    <= '0;
            length_reg  <= LENGTH_BITS'(1);
            follow_reg  <= 1'b0;
            base_reg    <= '0;
            refresh_reg <= 1'b1;
        end
        else
        begin
            refresh_reg <= cfg_valid;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_PATTERN_0:      pattern_reg[0] <= cfg_data;
                    REG_PATTERN_1:      pattern_reg[1] <= cfg_data;
                    REG_PATTERN_2:      pattern_reg[2] <= cfg_data;
                    REG_PATTERN_3:      pattern_reg[3] <= cfg_data;
                    REG_CARE_MASK:      care_reg       <= cfg_data[PATTERN_SLOTS-1:0];
                    REG_PATTERN_LENGTH: length_reg     <= cfg_data[LENGTH_BITS-1:0];
                    REG_FOLLOW_MODE:    follow_reg     <= cfg_data[0];
                    REG_BASE_ADDRESS:   base_reg       <= cfg_data[VALUE_BITS-1:0];
                    default:            ;
                endcase
            end
        end
    end

    mbss_align #(
        .MAX_BYTES(MAX_PATTERN_BYTES)
    ) u_align (
        .clk            (clk),
        .pattern_flat   (pattern_reg),
        .care_mask      (care_reg),
        .pattern_length (length_reg),
        .base_address   (base_reg),
        .aligned_byte   (aligned_byte),
        .aligned_care   (aligned_care),
        .setup          (setup)
    );

    // The cycle after a configuration write the aligned pattern is stale.
    assign in_stall  = refresh_reg || (out_valid_reg && out_stall);
    assign in_accept = in_valid && !in_stall;
    assign shift_en  = in_accept && !given_reg && !collecting_reg;
    assign chain[0]  = data_byte;

    for (genvar j = 0; j < MAX_PATTERN_BYTES; j++)
    begin : g_cell
        if (j < MAX_PATTERN_BYTES - 1)
        begin : g_mid
            mbss_cell u_cell (
                .clk          (clk),
                .shift_en     (shift_en),
                .byte_in      (chain[j]),
                .pattern_byte (aligned_byte[j]),
                .care         (aligned_care[j]),
                .byte_out     (chain[j+1]),
                .hit          (hit[j])
            );
        end
        else
        begin : g_end
            mbss_cell u_cell (
                .clk          (clk),
                .shift_en     (shift_en),
                .byte_in      (chain[j]),
                .pattern_byte (aligned_byte[j]),
                .care         (aligned_care[j]),
                .byte_out     (),
                .hit          (hit[j])
            );
        end
    end

    // Slots past the pattern length are masked off, and the offset check keeps
    // the match inside the bytes of the current region.
    assign window_hit = (&hit) && (offset_reg >= OFFSET_BITS'(setup.len_m1));

    always_comb
    begin
        offset_next     = offset_reg;
        given_next      = given_reg;
        collecting_next = collecting_reg;
        fcount_next     = fcount_reg;
        fword_next      = fword_reg;
        emit            = 1'b0;
        emit_status     = STATUS_NOT_FOUND;
        emit_value      = '0;
        if (in_accept)
        begin
            if (given_reg)
            begin
                emit = 1'b0;
            end
            else if (collecting_reg)
            begin
                fword_next[{fcount_reg, 3'b000} +: BYTE_BITS] = data_byte;
                fcount_next = fcount_reg + FOLLOW_COUNT_BITS'(1);
                if (fcount_reg == FOLLOW_LAST_BYTE)
                begin
                    emit            = 1'b1;
                    emit_status     = STATUS_FOUND;
                    emit_value      = {data_byte, fword_reg[VALUE_BITS-BYTE_BITS-1:0]};
                    given_next      = 1'b1;
                    collecting_next = 1'b0;
                end
                else if (last_byte)
                begin
                    emit        = 1'b1;
                    emit_status = STATUS_CUT_SHORT;
                end
            end
            else
            begin
                if (offset_reg != '1)
                begin
                    offset_next = offset_reg + OFFSET_BITS'(1);
                end
                if (window_hit)
                begin
                    if (!follow_reg)
                    begin
                        emit        = 1'b1;
                        emit_status = STATUS_FOUND;
                        emit_value  = (setup.base_adj + offset_reg) & ADDR_MASK;
                        given_next  = 1'b1;
                    end
                    else
                    begin
                        collecting_next = 1'b1;
                        fcount_next     = '0;
                        fword_next      = '0;
                        if (last_byte)
                        begin
                            emit        = 1'b1;
                            emit_status = STATUS_CUT_SHORT;
                        end
                    end
                end
                else if (last_byte)
                begin
                    emit        = 1'b1;
                    emit_status = STATUS_NOT_FOUND;
                end
            end
            if (last_byte)
            begin
                offset_next     = '0;
                given_next      = 1'b0;
                collecting_next = 1'b0;
                fcount_next     = '0;
                fword_next      = '0;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg     <= '0;
            given_reg      <= 1'b0;
            collecting_reg <= 1'b0;
            fcount_reg     <= '0;
            fword_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            offset_reg     <= offset_next;
            given_reg      <= given_next;
            collecting_reg <= collecting_next;
            fcount_reg     <= fcount_next;
            fword_reg      <= fword_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            status_reg <= emit_status;
            value_reg  <= emit_value;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign value     = value_reg;

    a_collect_excl: assert property (@(posedge clk) disable iff (!rst_n)
        collecting_reg |-> !given_reg)
        else $error("follow collection active after the region already answered");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !in_accept)
        else $error("byte taken while a held result occupies the output register");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (status_reg <= STATUS_CUT_SHORT))
        else $error("result carries an undefined status code");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && last_byte) |=> (offset_reg == '0) && !given_reg && !collecting_reg)
        else $error("scan state not cleared after the final byte of a region");

    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != STATUS_FOUND)) |-> (value_reg == '0))
        else $error("nonzero value on a not-found or cut-short result");

endmodule

[tb/sv/masked_byte_signature_scan_test.sv]
`timescale 1ns / 1ps

module masked_byte_signature_scan_test;

    import mbss_pkg::*;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [VALUE_BITS-1:0]  value;
    } scan_answer_t;

    // Scoreboard with its own copy of the scan state and registers.
    class scan_scoreboard;
        logic [PATTERN_WORD_BITS-1:0] pattern_word [PATTERN_WORDS];
        logic [31:0]                  care_bits;
        logic [LENGTH_BITS-1:0]       length_reg;
        logic                         follow_on;
        logic [31:0]                  base_addr;

        logic [BYTE_BITS-1:0]         window [PATTERN_SLOTS];
        logic [OFFSET_BITS-1:0]       offset;
        bit                           answered;
        bit                           collecting;
        int unsigned                  follow_count;
        logic [VALUE_BITS-1:0]        follow_word;

        scan_answer_t                 pending_answers [$];
        int                           mismatch_count;

        function new();
            for (int i = 0; i < PATTERN_WORDS; i++)
                pattern_word[i] = '0;
            care_bits = '0;
            length_reg = 6'd1;
            follow_on = 1'b0;
            base_addr = '0;
            mismatch_count = 0;
            restart_region();
        endfunction

        function void restart_region();
            for (int i = 0; i < PATTERN_SLOTS; i++)
                window[i] = '0;
            offset = '0;
            answered = 0;
            collecting = 0;
            follow_count = 0;
            follow_word = '0;
        endfunction

        function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                REG_PATTERN_0:      pattern_word[0] = data;
                REG_PATTERN_1:      pattern_word[1] = data;
                REG_PATTERN_2:      pattern_word[2] = data;
                REG_PATTERN_3:      pattern_word[3] = data;
                REG_CARE_MASK:      care_bits = data[31:0];
                REG_PATTERN_LENGTH: length_reg = data[LENGTH_BITS-1:0];
                REG_FOLLOW_MODE:    follow_on = data[0];
                REG_BASE_ADDRESS:   base_addr = data[31:0];
                default:            ;
            endcase
        endfunction

        function int used_len();
            if (length_reg == 0)
                return 1;
            if (length_reg > PATTERN_SLOTS)
                return PATTERN_SLOTS;
            return length_reg;
        endfunction

        function logic [BYTE_BITS-1:0] pattern_byte(int k);
            return pattern_word[k / 8][(k % 8) * 8 +: 8];
        endfunction

        function bit window_hit(int len);
            for (int k = 0; k < len; k++)
                if (care_bits[k] && window[len - 1 - k] != pattern_byte(k))
                    return 0;
            return 1;
        endfunction

        function void expect_answer(logic [STATUS_BITS-1:0] status, logic [VALUE_BITS-1:0] value);
            scan_answer_t a;
            a.status = status;
            a.value = value;
            pending_answers.push_back(a);
        endfunction

        // Called for every byte transaction the block accepts.
        function void take_byte(logic [BYTE_BITS-1:0] d, logic last);
            int          len;
            logic [32:0] count;
            logic [63:0] sum;
            if (answered) begin
                if (last)
                    restart_region();
                return;
            end
            if (collecting) begin
                follow_word |= {24'd0, d} << (8 * (follow_count % 4));
                follow_count++;
                if (follow_count >= 4) begin
                    expect_answer(STATUS_FOUND, follow_word);
                    answered = 1;
                    collecting = 0;
                end else if (last) begin
                    expect_answer(STATUS_CUT_SHORT, '0);
                end
                if (last)
                    restart_region();
                return;
            end
            len = used_len();
            count = {1'b0, offset} + 33'd1;
            for (int i = PATTERN_SLOTS - 1; i > 0; i--)
                window[i] = window[i - 1];
            window[0] = d;
            if (offset != '1)
                offset++;
            if (count >= len && window_hit(len)) begin
                if (!follow_on) begin
                    sum = {32'd0, base_addr} + {31'd0, count} - 64'(len);
                    expect_answer(STATUS_FOUND, sum[31:0] & ADDR_MASK);
                    answered = 1;
                end else begin
                    collecting = 1;
                    follow_count = 0;
                    follow_word = '0;
                    if (last)
                        expect_answer(STATUS_CUT_SHORT, '0);
                end
            end else if (last) begin
                expect_answer(STATUS_NOT_FOUND, '0);
            end
            if (last)
                restart_region();
        endfunction

        function void check_answer(logic [STATUS_BITS-1:0] status, logic [VALUE_BITS-1:0] value);
            scan_answer_t a;
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected result, status %0d value %h", $time, status, value);
                mismatch_count++;
                return;
            end
            a = pending_answers.pop_front();
            if (status !== a.status) begin
                $display("%0t: status expected %0d, actual %0d", $time, a.status, status);
                mismatch_count++;
            end
            if (value !== a.value) begin
                $display("%0t: value expected %h, actual %h", $time, a.value, value);
                mismatch_count++;
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic [BYTE_BITS-1:0]      data_byte;
    logic                      last_byte;
    logic                      out_valid;
    logic                      out_stall;
    logic [STATUS_BITS-1:0]    status;
    logic [VALUE_BITS-1:0]     value;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    scan_scoreboard sb;
    int             send_idle_pct;
    int             recv_stall_pct;
    bit             long_hold_request;
    int unsigned    bytes_sent;

    masked_byte_signature_scan dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .value     (value),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Results are checked before the byte of the same edge is noted, so a
    // byte can never satisfy a result that left the block at that edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_answer(status, value);
            if (in_valid && !in_stall)
                sb.take_byte(data_byte, last_byte);
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_request)
            begin
                long_hold_request = 0;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    initial
    begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    task automatic send_byte(logic [BYTE_BITS-1:0] d, logic last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= d;
        last_byte <= last;
        do
            @(posedge clk);
        while (in_stall);
        bytes_sent++;
    endtask

    // Leaves cfg_valid high; the caller lowers it after the last write.
    task automatic cfg_write(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, data);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending_answers.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_setting(logic [63:0] p0, logic [63:0] p1, logic [63:0] p2,
                                 logic [63:0] p3, logic [31:0] care, logic [5:0] len,
                                 logic follow, logic [31:0] base);
        wait_idle();
        cfg_write(REG_PATTERN_0, p0);
        cfg_write(REG_PATTERN_1, p1);
        cfg_write(REG_PATTERN_2, p2);
        cfg_write(REG_PATTERN_3, p3);
        cfg_write(REG_CARE_MASK, {32'($urandom), care});
        cfg_write(REG_PATTERN_LENGTH, {32'($urandom), 26'($urandom), len});
        cfg_write(REG_FOLLOW_MODE, {32'($urandom), 31'($urandom), follow});
        cfg_write(REG_BASE_ADDRESS, {32'($urandom), base});
        cfg_valid <= 1'b0;
    endtask

    // Mostly regions that carry the pattern with random wildcard bytes and
    // random follow bytes, some with one pattern byte flipped, some pure noise.
    task automatic send_region();
        logic [BYTE_BITS-1:0] q [$];
        logic [BYTE_BITS-1:0] b;
        int kind;
        int len;
        int bad;
        kind = $urandom_range(0, 99);
        len = sb.used_len();
        if (kind < 20)
        begin
            repeat ($urandom_range(1, 12)) q.push_back(8'($urandom));
        end
        else
        begin
            repeat ($urandom_range(0, 6)) q.push_back(8'($urandom));
            bad = (kind < 35) ? $urandom_range(0, len - 1) : -1;
            for (int k = 0; k < len; k++)
            begin
                b = sb.care_bits[k] ? sb.pattern_byte(k) : 8'($urandom);
                if (k == bad)
                    b = b ^ (8'd1 << $urandom_range(0, 7));
                q.push_back(b);
            end
            repeat ($urandom_range(0, 6)) q.push_back(8'($urandom));
            repeat ($urandom_range(0, 3)) q.push_back(8'($urandom));
        end
        for (int i = 0; i < q.size(); i++)
            send_byte(q[i], i == q.size() - 1);
    endtask

    initial
    begin
        logic [63:0] pw [4];
        logic [31:0] care;
        logic [5:0]  len;
        logic [31:0] base;
        int unsigned start_count;
        sb = new();
        bytes_sent = 0;
        long_hold_request = 0;
        send_idle_pct = 29;
        recv_stall_pct = 57;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        data_byte <= '0;
        last_byte <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting: a single wildcard byte matches the first byte.
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);

        // Match address that wraps past the top of the address space.
        apply_setting(64'hDEAD_BEEF_4433_2211, '1, '0, 64'h0123_4567_89AB_CDEF,
                      32'h0000_000F, 6'd4, 1'b0, 32'hFFFF_FFFE);
        send_byte(8'hAA, 1'b0);
        send_byte(8'hBB, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h33, 1'b0);
        send_byte(8'h44, 1'b1);
        // The pattern split across a region end must not match.
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h33, 1'b1);
        send_byte(8'h44, 1'b0);
        send_byte(8'h00, 1'b1);

        // Follow mode with a trailing wildcard: full word, match on the last
        // byte, and a word cut short by the region end.
        apply_setting(64'h0000_0000_0000_005A, '0, '1, '0,
                      32'h0000_0001, 6'd2, 1'b1, 32'h0000_1000);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h77, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h77, 1'b1);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFE, 1'b1);

        // Registers rewritten in the middle of a region.
        send_byte(8'h00, 1'b0);
        wait_idle();
        cfg_write(REG_BASE_ADDRESS, 64'hFFFF_0000_0000_2000);
        cfg_write(REG_FOLLOW_MODE, 64'h8000_0000_0000_0000);
        cfg_valid <= 1'b0;
        send_byte(8'h5A, 1'b0);
        send_byte(8'h01, 1'b1);

        for (int g = 0; g < 3; g++)
        begin
            for (int p = 0; p < 4; p++)
            begin
                for (int i = 0; i < 4; i++)
                    pw[i] = {32'($urandom), 32'($urandom)};
                base = $urandom;
                case (p)
                    0:
                    begin
                        for (int i = 0; i < 4; i++)
                            pw[i] = '1;
                        care = '1;
                        len = 6'd32;
                        base = '1;
                    end
                    1:
                    begin
                        for (int i = 0; i < 4; i++)
                            pw[i] = '0;
                        care = $urandom;
                        len = 6'd0;
                        base = '0;
                    end
                    2:
                    begin
                        care = $urandom | $urandom;
                        len = (g == 0) ? 6'd63 : 6'($urandom_range(33, 62));
                    end
                    default:
                    begin
                        care = ($urandom_range(0, 1) == 1) ? $urandom : ($urandom & $urandom);
                        len = 6'($urandom_range(1, 12));
                    end
                endcase
                apply_setting(pw[0], pw[1], pw[2], pw[3], care, len, 1'((p + g) % 2), base);
                if (g == 0 && p == 0)
                begin
                    // An index beyond the register list is accepted and ignored.
                    @(posedge clk);
                    cfg_write(CFG_INDEX_BITS'(REG_BASE_ADDRESS + $urandom_range(1, 8)),
                              {32'($urandom), 32'($urandom)});
                    cfg_valid <= 1'b0;
                end
                case (g)
                    0:
                    begin
                        send_idle_pct = 29;
                        recv_stall_pct = 57;
                    end
                    1:
                    begin
                        send_idle_pct = 57;
                        recv_stall_pct = 29;
                    end
                    default:
                    begin
                        send_idle_pct = 0;
                        recv_stall_pct = 0;
                    end
                endcase
                if (g == 2 && p == 0)
                    long_hold_request = 1;
                start_count = bytes_sent;
                while (bytes_sent - start_count < 138)
                    send_region();
            end
        end

        in_valid <= 1'b0;
        while (sb.pending_answers.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
